[rtl/core/gdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gdc_pkg;

    // Field widths
    localparam int YEAR_W     = 14;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;

    // Configuration register indexes
    localparam logic [0:0] CFG_FIRST_YEAR = 1'b0;
    localparam logic [0:0] CFG_YEAR_LIMIT = 1'b1;

    localparam logic [YEAR_W-1:0] FIRST_YEAR_RST = 14'd1901;
    localparam logic [YEAR_W-1:0] YEAR_LIMIT_RST = 14'd2100;

    // Operation codes
    localparam logic FUNC_CHECK = 1'b0;
    localparam logic FUNC_INDEX = 1'b1;

    // Reciprocals: x/100 = (x*5243)>>19, x/7 = (x*18725)>>17, small x/7 = (x*293)>>11
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam logic [14:0] RECIP_7     = 15'd18725;
    localparam logic [8:0]  RECIP_7_SML = 9'd293;
    localparam logic [14:0] CYCLE_SHIFT = 15'd399;

    typedef struct packed {
        logic [8:0]        day_index;
        logic [5:0]        second;
        logic [5:0]        minute;
        logic [4:0]        hour;
        logic [4:0]        day;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
        logic              func;
    } in_t;

    // After the divide stage
    typedef struct packed {
        logic              func;
        logic [YEAR_W-1:0] year;
        logic [14:0]       yw;
        logic [7:0]        q100y;
        logic [7:0]        q100w;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [8:0]        day_index;
        logic              year_ok;
        logic              time_ok;
    } s1_t;

    // After the leap stage
    typedef struct packed {
        logic        func;
        logic        leap;
        logic [14:0] s0;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [8:0]  day_index;
        logic        ok;
    } s2_t;

    // After the lookup stage
    typedef struct packed {
        logic       func;
        logic       leap;
        logic       date_ok;
        logic [8:0] year_day;
        logic [4:0] month_length;
        logic [2:0] s7;
        logic       idx_ok;
        logic [3:0] found_month;
        logic [4:0] found_day;
    } s3_t;

    typedef struct packed {
        logic [4:0] found_day;
        logic [3:0] found_month;
        logic [8:0] year_length;
        logic [4:0] month_length;
        logic [8:0] year_day;
        logic [2:0] week_day;
        logic       leap_year;
        logic       valid_res;
    } res_t;

    // Days in the first m months (m = 0..12); 0 for meaningless codes
    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            4'd12:   d = 9'd365;
            default: d = 9'd0;
        endcase
        if (leap && m >= 4'd2 && m <= 4'd12) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

    // Month length, 0 for a bad month
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] d;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/core/gdc_divide.sv]
`timescale 1ns / 1ps
`default_nettype none

// Stage 1: century quotients by reciprocal multiply, range checks
module gdc_divide
    import gdc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [YEAR_W-1:0] first_year,
    input  wire logic [YEAR_W-1:0] year_limit,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_t               in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output s1_t                    out_data
);

    logic       valid_reg;
    s1_t        data_reg;
    s1_t        data_next;
    logic [14:0] yw;
    logic [26:0] prod_y;
    logic [27:0] prod_w;

    assign yw     = 15'(in_data.year) + CYCLE_SHIFT;
    assign prod_y = 27'(in_data.year) * 27'(RECIP_100);
    assign prod_w = 28'(yw) * 28'(RECIP_100);

    always_comb begin
        data_next           = '0;
        data_next.func      = in_data.func;
        data_next.year      = in_data.year;
        data_next.yw        = yw;
        data_next.q100y     = prod_y[26:19];
        data_next.q100w     = prod_w[26:19];
        data_next.month     = in_data.month;
        data_next.day       = in_data.day;
        data_next.day_index = in_data.day_index;
        data_next.year_ok   = (in_data.year >= first_year) && (in_data.year < year_limit);
        data_next.time_ok   = (in_data.hour <= 5'd23) && (in_data.minute <= 6'd59)
                              && (in_data.second <= 6'd59);
    end

    // Stage handshake
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/gdc_leap.sv]
`timescale 1ns / 1ps
`default_nettype none

// Stage 2: leap flag, weekday partial sum, month/day code checks
module gdc_leap
    import gdc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire s1_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output s2_t       out_data
);

    logic        valid_reg;
    s2_t         data_reg;
    s2_t         data_next;
    logic [13:0] cent_y;
    logic        zero100;
    logic [15:0] sum;

    // year % 100 == 0 iff year equals its century times 100
    assign cent_y  = 14'({in_data.q100y, 6'b0}) + 14'({in_data.q100y, 5'b0})
                   + 14'({in_data.q100y, 2'b0});
    assign zero100 = (cent_y == in_data.year);

    // y + y/4 - y/100 + y/400
    assign sum = 16'(in_data.yw) + 16'(in_data.yw[14:2]) - 16'(in_data.q100w)
               + 16'(in_data.q100w[7:2]);

    always_comb begin
        data_next           = '0;
        data_next.func      = in_data.func;
        data_next.leap      = ((in_data.year[1:0] == 2'b00) && !zero100)
                              || (zero100 && (in_data.q100y[1:0] == 2'b00));
        data_next.s0        = sum[14:0];
        data_next.month     = in_data.month;
        data_next.day       = in_data.day;
        data_next.day_index = in_data.day_index;
        data_next.ok        = in_data.year_ok && in_data.time_ok
                              && (in_data.month >= 4'd1) && (in_data.month <= 4'd12)
                              && (in_data.day != 5'd0);
    end

    // Stage handshake
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/gdc_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none

// Stage 3: month tables, day of year, index search, partial sum mod 7
module gdc_lookup
    import gdc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire s2_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output s3_t       out_data
);

    logic        valid_reg;
    s3_t         data_reg;
    s3_t         data_next;
    logic [4:0]  mlen;
    logic        date_ok;
    logic [8:0]  yday;
    logic [29:0] prod7;
    logic [11:0] q7;
    logic [14:0] mul7;
    logic [14:0] rem7;
    logic        idx_ok;
    logic [3:0]  fm;
    logic [8:0]  base;
    logic [8:0]  offs;

    assign mlen    = month_len(in_data.leap, in_data.month);
    assign date_ok = in_data.ok && (in_data.day <= mlen);
    assign yday    = cum_days(in_data.leap, in_data.month - 4'd1) + 9'(in_data.day);

    // s0 mod 7
    assign prod7 = 30'(in_data.s0) * 30'(RECIP_7);
    assign q7    = prod7[28:17];
    assign mul7  = 15'({q7, 3'b000}) - 15'(q7);
    assign rem7  = in_data.s0 - mul7;

    // First month whose end lies past the index
    always_comb begin
        idx_ok = 1'b0;
        fm     = 4'd0;
        base   = 9'd0;
        for (int i = 11; i >= 0; i--) begin
            if (in_data.day_index < cum_days(in_data.leap, 4'(i + 1))) begin
                idx_ok = 1'b1;
                fm     = 4'(i + 1);
                base   = cum_days(in_data.leap, 4'(i));
            end
        end
    end

    assign offs = in_data.day_index - base + 9'd1;

    always_comb begin
        data_next      = '0;
        data_next.func = in_data.func;
        data_next.leap = in_data.leap;
        data_next.s7   = rem7[2:0];
        if (in_data.func == FUNC_CHECK) begin
            data_next.date_ok      = date_ok;
            data_next.month_length = mlen;
            data_next.year_day     = date_ok ? yday : 9'd0;
        end else begin
            data_next.idx_ok      = idx_ok;
            data_next.found_month = idx_ok ? fm : 4'd0;
            data_next.found_day   = idx_ok ? offs[4:0] : 5'd0;
        end
    end

    // Stage handshake
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/gdc_format.sv]
`timescale 1ns / 1ps
`default_nettype none

// Stage 4: final weekday reduction and result register
module gdc_format
    import gdc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire s3_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_data
);

    logic        valid_reg;
    res_t        data_reg;
    res_t        data_next;
    logic [9:0]  wsum;
    logic [18:0] prod7;
    logic [5:0]  q7;
    logic [9:0]  mul7;
    logic [9:0]  rem7;

    // (s0 mod 7 + day of year) mod 7
    assign wsum  = 10'(in_data.s7) + 10'(in_data.year_day);
    assign prod7 = 19'(wsum) * 19'(RECIP_7_SML);
    assign q7    = prod7[16:11];
    assign mul7  = 10'({q7, 3'b000}) - 10'(q7);
    assign rem7  = wsum - mul7;

    always_comb begin
        data_next              = '0;
        data_next.leap_year    = in_data.leap;
        data_next.year_length  = in_data.leap ? 9'd366 : 9'd365;
        data_next.month_length = in_data.month_length;
        data_next.year_day     = in_data.year_day;
        data_next.found_month  = in_data.found_month;
        data_next.found_day    = in_data.found_day;
        if (in_data.func == FUNC_CHECK) begin
            data_next.valid_res = in_data.date_ok;
            data_next.week_day  = in_data.date_ok ? rem7[2:0] : 3'd0;
        end else begin
            data_next.valid_res = in_data.idx_ok;
        end
    end

    // Output register
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/gregorian_date_checker.sv]
// Channel   Dir  Handshake               Payload
// s_        in   s_tvalid / s_tready     s_tuser = func, s_tdata = date, time, day index
// m_        out  m_tvalid / m_tready     m_tdata = result fields
// cfg_      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Four register stages: divide, leap, lookup, output. One request per cycle is taken
// unless back-pressure reaches s_; each stage holds while the one after it is full
// and stalled, so a stall at m_ back-pressures stage by stage with nothing lost.
// Reset clears the stage valid bits and loads the year window (years 1901 to 2099).
// Config writes are always ready and are registered.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_checker
    import gdc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [13:0] year, [17:14] month, [22:18] day, [27:23] hour, [33:28] minute,
    // [39:34] second, [48:40] day_index, rest zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [0] func
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] valid_res, [1] leap_year, [4:2] week_day, [13:5] year_day,
    // [18:14] month_length, [27:19] year_length, [31:28] found_month,
    // [36:32] found_day, rest zero
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [YEAR_W-1:0]     cfg_data
);

    logic [YEAR_W-1:0] first_year_reg;
    logic [YEAR_W-1:0] year_limit_reg;
    in_t               in_data;
    s1_t               s1_data;
    s2_t               s2_data;
    s3_t               s3_data;
    res_t              res_data;
    logic              s1_valid, s1_ready;
    logic              s2_valid, s2_ready;
    logic              s3_valid, s3_ready;

    // Year window registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_year_reg <= FIRST_YEAR_RST;
            year_limit_reg <= YEAR_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FIRST_YEAR: first_year_reg <= cfg_data;
                CFG_YEAR_LIMIT: year_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack request
    always_comb begin
        in_data           = '0;
        in_data.func      = s_tuser;
        in_data.year      = s_tdata[13:0];
        in_data.month     = s_tdata[17:14];
        in_data.day       = s_tdata[22:18];
        in_data.hour      = s_tdata[27:23];
        in_data.minute    = s_tdata[33:28];
        in_data.second    = s_tdata[39:34];
        in_data.day_index = s_tdata[48:40];
    end

    gdc_divide u_divide (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .first_year (first_year_reg),
        .year_limit (year_limit_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (in_data),
        .out_valid  (s1_valid),
        .out_ready  (s1_ready),
        .out_data   (s1_data)
    );

    gdc_leap u_leap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    gdc_lookup u_lookup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    gdc_format u_format (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_data   (s3_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    // Pack result
    assign m_tdata = {3'b000, res_data.found_day, res_data.found_month,
                      res_data.year_length, res_data.month_length, res_data.year_day,
                      res_data.week_day, res_data.leap_year, res_data.valid_res};

    // Result consistency checks
    a_year_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_data.year_length == (res_data.leap_year ? 9'd366 : 9'd365)))
        else $error("year length does not match leap flag");

    a_found_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((res_data.found_month == 4'd0) == (res_data.found_day == 5'd0)))
        else $error("found month and day disagree");

    a_week_day: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_data.week_day <= 3'd6))
        else $error("week day out of range");

    a_year_day: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_data.year_day != 9'd0) |->
        (res_data.valid_res && res_data.year_day <= res_data.year_length))
        else $error("day of year inconsistent");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid && !s3_ready) |=> s3_valid)
        else $error("stage three lost a stalled request");

endmodule

`default_nettype wire

[tb/sv/tb_gregorian_date_checker.sv]
`timescale 1ns / 1ps

module tb_gregorian_date_checker;
    import gdc_pkg::*;

    // Calendar predictor and queue of expected results
    class gdc_scoreboard;
        res_t expected_q[$];
        int   first_year;
        int   year_limit;
        int   errors;
        int   checked;
        int   good_dates;
        int   good_indexes;

        function new();
            first_year   = FIRST_YEAR_RST;
            year_limit   = YEAR_LIMIT_RST;
            errors       = 0;
            checked      = 0;
            good_dates   = 0;
            good_indexes = 0;
        endfunction

        static function bit is_leap(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int days_in_month(bit leap, int m);
            if (m < 1 || m > 12) begin
                return 0;
            end
            if (m == 2) begin
                return leap ? 29 : 28;
            end
            if (m == 4 || m == 6 || m == 9 || m == 11) begin
                return 30;
            end
            return 31;
        endfunction

        static function int days_before(bit leap, int m);
            int sum;
            sum = 0;
            for (int k = 1; k < m; k++) begin
                sum += days_in_month(leap, k);
            end
            return sum;
        endfunction

        function void set_reg(logic [0:0] idx, logic [YEAR_W-1:0] val);
            if (idx == CFG_FIRST_YEAR) begin
                first_year = val;
            end else begin
                year_limit = val;
            end
        endfunction

        // Expected result for one request
        function res_t describe(in_t r);
            res_t e;
            bit   leap;
            int   mlen;
            int   yday;
            int   y;
            int   wd;
            int   rem;
            int   m;
            e    = '0;
            leap = is_leap(r.year);
            e.leap_year   = leap;
            e.year_length = leap ? 9'd366 : 9'd365;
            if (r.func == FUNC_CHECK) begin
                mlen = days_in_month(leap, r.month);
                e.month_length = mlen[4:0];
                if (r.hour <= 23 && r.minute <= 59 && r.second <= 59 &&
                    r.year >= first_year && r.year < year_limit &&
                    mlen != 0 && r.day >= 1 && r.day <= mlen) begin
                    yday = days_before(leap, r.month) + r.day;
                    // 400 years are a whole number of weeks, so the shift keeps year 0 sane
                    y  = r.year + 399;
                    wd = (y + y / 4 - y / 100 + y / 400 + yday) % 7;
                    e.valid_res = 1'b1;
                    e.year_day  = yday[8:0];
                    e.week_day  = wd[2:0];
                end
            end else if (r.day_index < (leap ? 366 : 365)) begin
                rem = r.day_index;
                m   = 1;
                while (rem >= days_in_month(leap, m)) begin
                    rem -= days_in_month(leap, m);
                    m++;
                end
                e.valid_res   = 1'b1;
                e.found_month = m[3:0];
                e.found_day   = 5'(rem + 1);
            end
            return e;
        endfunction

        function void note_request(in_t r);
            expected_q.push_back(describe(r));
        endfunction

        function void check_field(string name, int e, int a);
            if (e != a) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, e, a);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            res_t a;
            res_t e;
            a = data[$bits(res_t)-1:0];
            checked++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: expected none, got %h",
                         $time, data);
                return;
            end
            e = expected_q.pop_front();
            check_field("valid_res", e.valid_res, a.valid_res);
            check_field("leap_year", e.leap_year, a.leap_year);
            check_field("week_day", e.week_day, a.week_day);
            check_field("year_day", e.year_day, a.year_day);
            check_field("month_length", e.month_length, a.month_length);
            check_field("year_length", e.year_length, a.year_length);
            check_field("found_month", e.found_month, a.found_month);
            check_field("found_day", e.found_day, a.found_day);
            if (e.valid_res && e.found_month != 0) begin
                good_indexes++;
            end else if (e.valid_res) begin
                good_dates++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    wire logic             s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    wire logic             m_tvalid;
    logic                  m_tready  = 1'b0;
    wire logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    wire logic             cfg_ready;
    logic [0:0]            cfg_index = '0;
    logic [YEAR_W-1:0]     cfg_data  = '0;

    gdc_scoreboard sb = new();

    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    int hold_reqs  = 0;
    int n_windows  = 1;

    gregorian_date_checker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d results still expected", sb.pending());
        $display("tb_gregorian_date_checker NOT OK");
        $finish;
    end

    // Result sink: random stalls, plus a long hold-off when asked for
    initial begin : result_sink
        int hold_ticks;
        int hold_seen;
        hold_ticks = 0;
        hold_seen  = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if (hold_seen != hold_reqs) begin
                hold_seen  = hold_reqs;
                hold_ticks = 250;
            end
            if (hold_ticks > 0) begin
                hold_ticks--;
                m_tready <= 1'b0;
            end else if (rx_idle_en) begin
                m_tready <= ($urandom_range(0, 99) >= 34);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic in_t mk(logic f, int y, int mo, int d, int h, int mi, int s,
                               int idx);
        in_t r;
        r.func      = f;
        r.year      = y[YEAR_W-1:0];
        r.month     = mo[3:0];
        r.day       = d[4:0];
        r.hour      = h[4:0];
        r.minute    = mi[5:0];
        r.second    = s[5:0];
        r.day_index = idx[8:0];
        return r;
    endfunction

    // Mostly well-formed dates inside the window, the rest full-range noise
    function automatic in_t random_request(int first, int limit);
        in_t r;
        bit  leap;
        int  mlen;
        r.func = ($urandom_range(0, 99) < 30) ? FUNC_INDEX : FUNC_CHECK;
        if (limit > first && $urandom_range(0, 99) < 70) begin
            r.year = YEAR_W'($urandom_range(limit - 1, first));
        end else begin
            r.year = YEAR_W'($urandom);
        end
        r.month = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 12)) : 4'($urandom);
        leap = gdc_scoreboard::is_leap(r.year);
        mlen = gdc_scoreboard::days_in_month(leap, r.month);
        if (mlen != 0 && $urandom_range(0, 99) < 85) begin
            r.day = 5'($urandom_range(1, mlen));
        end else begin
            r.day = 5'($urandom);
        end
        r.hour   = ($urandom_range(0, 99) < 90) ? 5'($urandom_range(0, 23)) : 5'($urandom);
        r.minute = ($urandom_range(0, 99) < 90) ? 6'($urandom_range(0, 59)) : 6'($urandom);
        r.second = ($urandom_range(0, 99) < 90) ? 6'($urandom_range(0, 59)) : 6'($urandom);
        if ($urandom_range(0, 99) < 80) begin
            r.day_index = 9'($urandom_range(0, 366));
        end else begin
            r.day_index = 9'($urandom);
        end
        return r;
    endfunction

    // One request; valid stays high between back-to-back requests
    task automatic push_request(input in_t r);
        // each cycle idles with the same odds, about a third of the time
        while (tx_idle_en && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= {7'b0, r.day_index, r.second, r.minute, r.hour, r.day, r.month, r.year};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    // Stop offering and wait for every expected result
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [YEAR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic set_window(input int first, input int limit);
        write_reg(CFG_FIRST_YEAR, first[YEAR_W-1:0]);
        write_reg(CFG_YEAR_LIMIT, limit[YEAR_W-1:0]);
        cfg_valid <= 1'b0;
        n_windows++;
    endtask

    initial begin : stimulus
        in_t directed[$];
        int  win_first[6];
        int  win_limit[6];
        int  edge_years[8];

        win_first = '{0, 1, 9999, 5000, 1600, 1};
        win_limit = '{16383, 10000, 10000, 10, 2401, 1};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests under the reset window
        directed.push_back(mk(FUNC_CHECK, 2024, 2, 29, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_CHECK, 2023, 2, 29, 12, 30, 30, 0));
        directed.push_back(mk(FUNC_CHECK, 2000, 12, 31, 23, 59, 59, 511));
        directed.push_back(mk(FUNC_CHECK, 1901, 1, 1, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_CHECK, 2099, 12, 31, 23, 59, 59, 0));
        directed.push_back(mk(FUNC_CHECK, 2100, 1, 1, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_CHECK, 1900, 6, 15, 8, 0, 0, 0));
        directed.push_back(mk(FUNC_CHECK, 2010, 0, 10, 1, 1, 1, 0));
        directed.push_back(mk(FUNC_CHECK, 2010, 13, 10, 1, 1, 1, 0));
        directed.push_back(mk(FUNC_CHECK, 16383, 15, 31, 31, 63, 63, 511));
        directed.push_back(mk(FUNC_CHECK, 2010, 4, 31, 1, 1, 1, 0));
        directed.push_back(mk(FUNC_CHECK, 2010, 5, 0, 1, 1, 1, 0));
        directed.push_back(mk(FUNC_CHECK, 2010, 7, 4, 24, 0, 0, 0));
        directed.push_back(mk(FUNC_CHECK, 2010, 7, 4, 0, 60, 0, 0));
        directed.push_back(mk(FUNC_CHECK, 2010, 7, 4, 0, 0, 60, 0));
        directed.push_back(mk(FUNC_CHECK, 0, 1, 1, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_INDEX, 2023, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_INDEX, 2024, 3, 3, 3, 3, 3, 59));
        directed.push_back(mk(FUNC_INDEX, 2023, 3, 3, 3, 3, 3, 59));
        directed.push_back(mk(FUNC_INDEX, 2023, 1, 1, 0, 0, 0, 364));
        directed.push_back(mk(FUNC_INDEX, 2023, 1, 1, 0, 0, 0, 365));
        directed.push_back(mk(FUNC_INDEX, 2024, 1, 1, 0, 0, 0, 365));
        directed.push_back(mk(FUNC_INDEX, 2024, 1, 1, 0, 0, 0, 366));
        directed.push_back(mk(FUNC_INDEX, 1900, 15, 31, 31, 63, 63, 511));
        directed.push_back(mk(FUNC_INDEX, 0, 0, 0, 0, 0, 0, 59));
        foreach (directed[i]) begin
            push_request(directed[i]);
        end

        // Reset window, both sides idling at random
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (85) push_request(random_request(sb.first_year, sb.year_limit));
        drain();

        for (int p = 0; p < 6; p++) begin
            set_window(win_first[p], win_limit[p]);

            // first window: no idling anywhere; third: long receiver hold-off
            tx_idle_en = (p != 0 && p != 2);
            rx_idle_en = (p != 0);
            if (p == 2) begin
                hold_reqs++;
            end

            // Window edges and century leap cases, all on Feb 29 at 23:59:59
            edge_years = '{0, 1900, 2000, 16383, win_first[p] - 1, win_first[p],
                           win_limit[p] - 1, win_limit[p]};
            foreach (edge_years[i]) begin
                push_request(mk(FUNC_CHECK, edge_years[i] & 16'h3FFF, 2, 29, 23, 59, 59,
                                $urandom_range(0, 511)));
            end
            repeat (80) push_request(random_request(sb.first_year, sb.year_limit));
            drain();
        end

        repeat (8) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: results never delivered: expected 0 pending, got %0d",
                     $time, sb.pending());
        end

        $display("Checked %0d results: %0d legal dates, %0d in-year day indexes, rest rejected",
                 sb.checked, sb.good_dates, sb.good_indexes);
        $display("Ran %0d year windows incl. empty ones, with stalls, hold-off and drains",
                 n_windows);
        if (sb.errors == 0) begin
            $display("tb_gregorian_date_checker OK");
        end else begin
            $display("tb_gregorian_date_checker NOT OK");
        end
        $finish;
    end

endmodule
